// ----- design/dpm_pkg.sv -----
// Package for the device presence matcher.
// Holds the transfer payload types, flag bit positions, the controller state type
// and the command and status structs. It depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dpm_pkg;

   localparam int ID_W = 64;
   localparam int CL_W = 45;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   localparam int FL_VENDEV   = 0;
   localparam int FL_SUBSYS   = 1;
   localparam int FL_REV      = 2;
   localparam int FL_CLASS    = 3;
   localparam int FL_PROGIF   = 4;
   localparam int FL_LOCALBUS = 5;
   localparam int FL_LOCALDEV = 6;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  bus_number;
      logic [4:0]  device_number;
      logic [15:0] vendor_id;
      logic [15:0] device_id;
      logic [15:0] subvendor_id;
      logic [15:0] subsystem_id;
      logic [7:0]  revision_id;
      logic [7:0]  base_class;
      logic [7:0]  sub_class;
      logic [7:0]  prog_if;
      logic [6:0]  match_flags;
   } dpm_req_type;

   typedef struct packed {
      logic found;
      logic flags_invalid;
      logic table_full;
   } dpm_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_RESP
   } dpm_state_type;

   typedef struct packed {
      logic load;
      logic write_entry;
      logic scan_issue;
      logic result_load;
   } dpm_cmd_type;

   typedef struct packed {
      logic is_query;
      logic full;
      logic issue_done;
      logic pending;
   } dpm_status_type;

endpackage
`default_nettype wire

// ----- design/dpm_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// Used for the device table stores; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module dpm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/dpm_ctrl.sv -----
// Controller state machine of the device presence matcher.
// Sequences inserts, table scans and result transfers; uses dpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dpm_ctrl
   import dpm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire dpm_status_type status,
   output dpm_cmd_type         cmd
);

   dpm_state_type state_ff;
   dpm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = status.is_query ? ST_SCAN : ST_RESP;
         end
         ST_SCAN: begin
            if (status.issue_done && !status.pending) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DECODE: begin
            if (!status.is_query) begin
               cmd.write_entry = !status.full;
               cmd.result_load = 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue  = !status.issue_done;
            cmd.result_load = status.issue_done && !status.pending;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- design/dpm_datapath.sv -----
// Datapath of the device presence matcher: request register, entry count,
// table stores, scan pointer, entry comparator and result register.
// Uses dpm_pkg and dpm_ram.
`timescale 1ns / 1ps
`default_nettype none
module dpm_datapath
   import dpm_pkg::*;
#(
   parameter int MAX_DEVICES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dpm_req_type req_data,
   input  wire dpm_cmd_type cmd,
   output dpm_status_type   status,
   output dpm_rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(MAX_DEVICES + 1);
   localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

   dpm_req_type      q_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             pend_ff;
   logic             hit_ff;
   dpm_rsp_type      rsp_ff;

   logic [ID_W-1:0]  wr_ids;
   logic [CL_W-1:0]  wr_cl;
   logic [ID_W-1:0]  e_ids;
   logic [CL_W-1:0]  e_cl;
   logic [6:0]       fl;
   logic             is_local;
   logic             match;
   logic             bad;

   assign wr_ids = {q_ff.subsystem_id, q_ff.subvendor_id,
                    q_ff.device_id, q_ff.vendor_id};
   assign wr_cl  = {q_ff.device_number, q_ff.bus_number, q_ff.prog_if,
                    q_ff.sub_class, q_ff.base_class, q_ff.revision_id};

   dpm_ram #(.WIDTH(ID_W), .DEPTH(MAX_DEVICES)) u_ids_ram (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_ids),
      .rd_en   (cmd.scan_issue),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (e_ids)
   );

   dpm_ram #(.WIDTH(CL_W), .DEPTH(MAX_DEVICES)) u_class_ram (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_cl),
      .rd_en   (cmd.scan_issue),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (e_cl)
   );

   assign fl       = q_ff.match_flags;
   assign is_local = fl[FL_LOCALBUS] || fl[FL_LOCALDEV];

   always_comb begin
      match = 1'b1;
      if (is_local && (e_cl[39:32] != q_ff.bus_number)) begin
         match = 1'b0;
      end
      if (fl[FL_LOCALDEV] && (e_cl[44:40] != q_ff.device_number)) begin
         match = 1'b0;
      end
      if (fl[FL_VENDEV]) begin
         if (e_ids[31:0] != {q_ff.device_id, q_ff.vendor_id}) begin
            match = 1'b0;
         end
         if (fl[FL_SUBSYS] && (e_ids[63:32] != {q_ff.subsystem_id, q_ff.subvendor_id})) begin
            match = 1'b0;
         end
         if (fl[FL_REV] && (e_cl[7:0] != q_ff.revision_id)) begin
            match = 1'b0;
         end
      end
      if (fl[FL_CLASS]) begin
         if (e_cl[23:8] != {q_ff.sub_class, q_ff.base_class}) begin
            match = 1'b0;
         end
         if (fl[FL_PROGIF] && (e_cl[31:24] != q_ff.prog_if)) begin
            match = 1'b0;
         end
      end
   end

   assign bad = (!fl[FL_VENDEV] && !fl[FL_CLASS]) ||
                ((fl[FL_SUBSYS] || fl[FL_REV]) && !fl[FL_VENDEV]) ||
                (fl[FL_PROGIF] && !fl[FL_CLASS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (cmd.write_entry) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         pend_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff   <= req_data;
         idx_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (cmd.scan_issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (pend_ff && match) begin
            hit_ff <= 1'b1;
         end
      end
      if (cmd.result_load) begin
         rsp_ff.found         <= (q_ff.req_type == REQ_QUERY) && hit_ff;
         rsp_ff.flags_invalid <= (q_ff.req_type == REQ_QUERY) && bad;
         rsp_ff.table_full    <= (q_ff.req_type == REQ_INSERT) &&
                                 (count_ff == CNT_W'(MAX_DEVICES));
      end
   end

   assign status.is_query   = (q_ff.req_type == REQ_QUERY);
   assign status.full       = (count_ff == CNT_W'(MAX_DEVICES));
   assign status.issue_done = (idx_ff == count_ff);
   assign status.pending    = pend_ff;
   assign rsp_data          = rsp_ff;

endmodule
`default_nettype wire

// ----- design/device_presence_matcher_top.sv -----
// Device presence matcher: a table of enumerated devices with insert and presence query.
// Instantiates dpm_ctrl and dpm_datapath (which holds two dpm_ram tables); uses dpm_pkg.
//
// Usage:
//   Requests arrive on the req_ channel (req_valid, req_stall, req_data) and each
//   yields exactly one result transfer on the rsp_ channel (rsp_valid, rsp_stall,
//   rsp_data). A transfer happens on a rising edge with valid high and stall low.
//   The block handles one request at a time: req_stall is high from the accepting
//   edge until the result transfer has completed.
//   An insert raises rsp_valid after the decode state. A query scans the stored entries
//   one per cycle through the registered table read port, then waits for the last
//   read to be compared before raising rsp_valid.
//   The result stays on rsp_data while rsp_stall is high, and no new request is
//   taken until the result has been transferred.
//   Synchronous reset empties the table (entry count to zero) and returns the
//   controller to idle; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module device_presence_matcher_top
   import dpm_pkg::*;
#(
   parameter int MAX_DEVICES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire dpm_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output dpm_rsp_type      rsp_data
);

   dpm_cmd_type    cmd;
   dpm_status_type status;

   dpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpm_datapath #(.MAX_DEVICES(MAX_DEVICES)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a previous request is in flight");

   a_insert_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !status.is_query) |-> (!rsp_data.found && !rsp_data.flags_invalid))
      else $error("insert result carries query bits");

   a_query_never_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status.is_query) |-> !rsp_data.table_full)
      else $error("query result reports table full");

   a_full_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.table_full) |-> status.full)
      else $error("table full reported while entries remain");

endmodule
`default_nettype wire

// ----- bench/tb_device_presence_matcher_top.sv -----
// Self-checking testbench for device_presence_matcher_top: inserts devices into the table and
// runs presence queries, predicting each result and comparing it field by field.
// Depends on dpm_pkg and device_presence_matcher_top.
`timescale 1ns / 1ps
module tb_device_presence_matcher_top
   import dpm_pkg::*;
();

   localparam int TABLE_DEPTH = 32;
   localparam int RANDOM_ITEMS = 1280;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_LIMIT = 100;

   localparam logic [6:0] M_VENDEV   = 7'b1 << FL_VENDEV;
   localparam logic [6:0] M_SUBSYS   = 7'b1 << FL_SUBSYS;
   localparam logic [6:0] M_REV      = 7'b1 << FL_REV;
   localparam logic [6:0] M_CLASS    = 7'b1 << FL_CLASS;
   localparam logic [6:0] M_PROGIF   = 7'b1 << FL_PROGIF;
   localparam logic [6:0] M_LOCALBUS = 7'b1 << FL_LOCALBUS;
   localparam logic [6:0] M_LOCALDEV = 7'b1 << FL_LOCALDEV;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   dpm_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   dpm_rsp_type rsp_data;

   dpm_req_type device_table[$];
   dpm_rsp_type expected_results[$];
   int          error_count = 0;
   int unsigned stall_left = 0;
   logic        steady_phase = 1'b0;

   device_presence_matcher_top #(
      .MAX_DEVICES(TABLE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic entry_hits(input dpm_req_type e, input dpm_req_type q);
      logic [6:0] f;
      f = q.match_flags;
      if ((f[FL_LOCALBUS] || f[FL_LOCALDEV]) && e.bus_number != q.bus_number) return 1'b0;
      if (f[FL_LOCALDEV] && e.device_number != q.device_number) return 1'b0;
      if (f[FL_VENDEV]) begin
         if (e.vendor_id != q.vendor_id || e.device_id != q.device_id) return 1'b0;
         if (f[FL_SUBSYS] && (e.subvendor_id != q.subvendor_id ||
                              e.subsystem_id != q.subsystem_id)) return 1'b0;
         if (f[FL_REV] && e.revision_id != q.revision_id) return 1'b0;
      end
      if (f[FL_CLASS]) begin
         if (e.base_class != q.base_class || e.sub_class != q.sub_class) return 1'b0;
         if (f[FL_PROGIF] && e.prog_if != q.prog_if) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic dpm_rsp_type predict_presence(input dpm_req_type r);
      dpm_rsp_type res;
      logic [6:0]  f;
      res = '0;
      f = r.match_flags;
      if (r.req_type == REQ_INSERT) begin
         if (device_table.size() >= TABLE_DEPTH) res.table_full = 1'b1;
         else device_table.push_back(r);
      end else begin
         if (!f[FL_VENDEV] && !f[FL_CLASS]) res.flags_invalid = 1'b1;
         if ((f[FL_SUBSYS] || f[FL_REV]) && !f[FL_VENDEV]) res.flags_invalid = 1'b1;
         if (f[FL_PROGIF] && !f[FL_CLASS]) res.flags_invalid = 1'b1;
         foreach (device_table[i])
            if (entry_hits(device_table[i], r)) res.found = 1'b1;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_request(input dpm_req_type r);
      int unsigned gap;
      gap = steady_phase ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(predict_presence(r));
   endtask

   // The stall drawn after each transfer counts down only while a result is offered.
   always @(posedge clock) begin : result_checker
      dpm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %b with nothing expected", rsp_data));
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %b, expected %b", rsp_data.found, want.found));
            if (rsp_data.flags_invalid !== want.flags_invalid)
               report_mismatch($sformatf("flags_invalid %b, expected %b",
                                         rsp_data.flags_invalid, want.flags_invalid));
            if (rsp_data.table_full !== want.table_full)
               report_mismatch($sformatf("table_full %b, expected %b",
                                         rsp_data.table_full, want.table_full));
         end
         stall_left = steady_phase ? 0 : $urandom_range(0, 4);
      end else if (rsp_valid && stall_left != 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left != 0);
   end

   function automatic dpm_req_type random_request(input logic kind);
      dpm_req_type r;
      r.req_type      = kind;
      r.bus_number    = 8'($urandom);
      r.device_number = 5'($urandom);
      r.vendor_id     = 16'($urandom);
      r.device_id     = 16'($urandom);
      r.subvendor_id  = 16'($urandom);
      r.subsystem_id  = 16'($urandom);
      r.revision_id   = 8'($urandom);
      r.base_class    = 8'($urandom);
      r.sub_class     = 8'($urandom);
      r.prog_if       = 8'($urandom);
      r.match_flags   = 7'($urandom);
      return r;
   endfunction

   function automatic dpm_req_type with_kind(input dpm_req_type r, input logic kind,
                                             input logic [6:0] flags);
      dpm_req_type p;
      p = r;
      p.req_type = kind;
      p.match_flags = flags;
      return p;
   endfunction

   function automatic dpm_req_type perturb_one_field(input dpm_req_type r);
      dpm_req_type p;
      p = r;
      case ($urandom_range(0, 9))
         0: p.bus_number    = p.bus_number ^ (8'b1 << $urandom_range(0, 7));
         1: p.device_number = p.device_number ^ (5'b1 << $urandom_range(0, 4));
         2: p.vendor_id     = p.vendor_id ^ (16'b1 << $urandom_range(0, 15));
         3: p.device_id     = p.device_id ^ (16'b1 << $urandom_range(0, 15));
         4: p.subvendor_id  = p.subvendor_id ^ (16'b1 << $urandom_range(0, 15));
         5: p.subsystem_id  = p.subsystem_id ^ (16'b1 << $urandom_range(0, 15));
         6: p.revision_id   = p.revision_id ^ (8'b1 << $urandom_range(0, 7));
         7: p.base_class    = p.base_class ^ (8'b1 << $urandom_range(0, 7));
         8: p.sub_class     = p.sub_class ^ (8'b1 << $urandom_range(0, 7));
         default: p.prog_if = p.prog_if ^ (8'b1 << $urandom_range(0, 7));
      endcase
      return p;
   endfunction

   // Most masks are repaired to respect the flag dependencies; the rest stay raw.
   function automatic logic [6:0] draw_flags();
      logic [6:0] f;
      f = 7'($urandom);
      if ($urandom_range(0, 9) < 7) begin
         if (!f[FL_VENDEV]) f = f & ~(M_SUBSYS | M_REV);
         if (!f[FL_CLASS]) f = f & ~M_PROGIF;
         if (!f[FL_VENDEV] && !f[FL_CLASS]) f = f | M_VENDEV;
      end
      return f;
   endfunction

   function automatic dpm_req_type pick_entry();
      return device_table[$urandom_range(0, device_table.size() - 1)];
   endfunction

   task automatic test_empty_table();
      send_request(with_kind(random_request(REQ_QUERY), REQ_QUERY, M_VENDEV));
      send_request(with_kind(random_request(REQ_QUERY), REQ_QUERY, '0));
   endtask

   task automatic test_insert_entries();
      dpm_req_type dev;
      send_request(with_kind('0, REQ_INSERT, '1));
      send_request(with_kind('1, REQ_INSERT, '0));
      dev = random_request(REQ_INSERT);
      send_request(dev);
      send_request(dev);
   endtask

   task automatic test_flag_rules();
      dpm_req_type ones;
      dpm_req_type dev;
      dpm_req_type q;
      ones = '1;
      dev = device_table[2];
      send_request(with_kind(ones, REQ_QUERY, M_VENDEV | M_SUBSYS | M_REV));
      q = ones;
      q.revision_id = 8'h7E;
      send_request(with_kind(q, REQ_QUERY, M_VENDEV | M_SUBSYS | M_REV));
      send_request(with_kind('0, REQ_QUERY, M_CLASS | M_PROGIF));
      send_request(with_kind(ones, REQ_QUERY, M_SUBSYS));
      send_request(with_kind(ones, REQ_QUERY, M_REV));
      send_request(with_kind(ones, REQ_QUERY, M_PROGIF));
      send_request(with_kind(dev, REQ_QUERY, M_VENDEV | M_PROGIF));
      send_request(with_kind(random_request(REQ_QUERY), REQ_QUERY, '0));
      send_request(with_kind(dev, REQ_QUERY, M_LOCALDEV | M_VENDEV));
      q = dev;
      q.device_number = ~dev.device_number;
      send_request(with_kind(q, REQ_QUERY, M_LOCALDEV | M_VENDEV));
      q = dev;
      q.bus_number = ~dev.bus_number;
      send_request(with_kind(q, REQ_QUERY, M_LOCALBUS | M_VENDEV));
      send_request(with_kind('0, REQ_QUERY, M_LOCALBUS));
   endtask

   // Queries are mostly built from stored entries so that matches and near misses both occur.
   task automatic test_random_traffic();
      dpm_req_type r;
      int          n;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 128 == 0) steady_phase = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < (device_table.size() < TABLE_DEPTH ? 40 : 5)) begin
            if ($urandom_range(0, 1) == 0) r = perturb_one_field(pick_entry());
            else r = random_request(REQ_INSERT);
            r.req_type = REQ_INSERT;
            r.match_flags = 7'($urandom);
         end else if ($urandom_range(0, 9) < 7) begin
            r = pick_entry();
            if ($urandom_range(0, 1) == 0) r = perturb_one_field(r);
            r = with_kind(r, REQ_QUERY, draw_flags());
         end else begin
            r = with_kind(random_request(REQ_QUERY), REQ_QUERY, draw_flags());
         end
         send_request(r);
      end
      steady_phase = 1'b0;
   endtask

   task automatic test_table_full();
      while (device_table.size() < TABLE_DEPTH)
         send_request(random_request(REQ_INSERT));
      send_request(random_request(REQ_INSERT));
      send_request(with_kind('1, REQ_INSERT, '1));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_insert_entries();
      test_flag_rules();
      test_random_traffic();
      test_table_full();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
